[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent assertions of the report differ.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_SAME(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("next-cycle check failed");

`endif

[src/hbkrd_pkg.sv]
// ----------------------------------------------------------------------------
// hbkrd_pkg
// Shared constants, types and helpers of the boot keyboard report differ.
// ----------------------------------------------------------------------------
package hbkrd_pkg;

    localparam int KEY_W          = 8;
    localparam int MOD_BITS       = 8;
    localparam int INPUT_SLOTS    = 6;
    localparam int KEY_SLOTS_DEF  = 6;

    typedef logic [KEY_W-1:0] t_key;

    localparam t_key ROLLOVER_CODE  = 8'h01;
    localparam t_key EMPTY_CODE     = 8'h00;
    localparam t_key MOD_USAGE_BASE = 8'hE0;

    // Slots that take part: only six exist in a report.
    function automatic int used_slots(input int key_slots);
        return (key_slots < INPUT_SLOTS) ? key_slots : INPUT_SLOTS;
    endfunction

endpackage

[src/hbkrd_lane.sv]
// ----------------------------------------------------------------------------
// hbkrd_lane
// One search lane: tells whether a key occurs in the live part of a list.
// ----------------------------------------------------------------------------
module hbkrd_lane #(
    parameter int SLOTS = hbkrd_pkg::KEY_SLOTS_DEF
) (
    input  hbkrd_pkg::t_key             i_key,
    input  hbkrd_pkg::t_key [SLOTS-1:0] i_list,
    input  logic [SLOTS-1:0]            i_live,
    output logic                        o_found
);

    logic [SLOTS-1:0] w_hit;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            w_hit[i] = i_live[i] && (i_list[i] == i_key);
        end
    end

    assign o_found = |w_hit;

endmodule

[src/hbkrd_merge.sv]
// ----------------------------------------------------------------------------
// hbkrd_merge
// Runs one press lane and one release lane per slot and merges their
// findings with the modifier changes into one ordered candidate list.
// ----------------------------------------------------------------------------
module hbkrd_merge #(
    parameter int SLOTS = hbkrd_pkg::KEY_SLOTS_DEF,
    parameter int NCAND = hbkrd_pkg::MOD_BITS + 2 * SLOTS
) (
    input  hbkrd_pkg::t_key             i_mods_new,
    input  hbkrd_pkg::t_key             i_mods_old,
    input  hbkrd_pkg::t_key [SLOTS-1:0] i_fresh,
    input  hbkrd_pkg::t_key [SLOTS-1:0] i_old,
    output logic [NCAND-1:0]            o_cand,
    output hbkrd_pkg::t_key [NCAND-1:0] o_usage,
    output logic [NCAND-1:0]            o_level
);

    localparam int MB = hbkrd_pkg::MOD_BITS;

    logic [SLOTS-1:0] w_live_new;
    logic [SLOTS-1:0] w_live_old;
    logic [SLOTS-1:0] w_in_old;
    logic [SLOTS-1:0] w_in_new;
    logic             w_rollover;

    // A list ends at its first empty slot.
    always_comb begin
        w_live_new[0] = (i_fresh[0] != hbkrd_pkg::EMPTY_CODE);
        w_live_old[0] = (i_old[0] != hbkrd_pkg::EMPTY_CODE);
        for (int i = 1; i < SLOTS; i++) begin
            w_live_new[i] = w_live_new[i-1] && (i_fresh[i] != hbkrd_pkg::EMPTY_CODE);
            w_live_old[i] = w_live_old[i-1] && (i_old[i] != hbkrd_pkg::EMPTY_CODE);
        end
    end

    // Rollover looks at every slot in use, empty slots or not.
    always_comb begin
        w_rollover = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (i_fresh[i] == hbkrd_pkg::ROLLOVER_CODE) begin
                w_rollover = 1'b1;
            end
        end
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_lane
        hbkrd_lane #(.SLOTS(SLOTS)) u_press (
            .i_key   (i_fresh[g]),
            .i_list  (i_old),
            .i_live  (w_live_old),
            .o_found (w_in_old[g])
        );
        hbkrd_lane #(.SLOTS(SLOTS)) u_release (
            .i_key   (i_old[g]),
            .i_list  (i_fresh),
            .i_live  (w_live_new),
            .o_found (w_in_new[g])
        );
    end

    always_comb begin
        for (int b = 0; b < MB; b++) begin
            o_cand[b]  = i_mods_new[b] ^ i_mods_old[b];
            o_usage[b] = hbkrd_pkg::MOD_USAGE_BASE + hbkrd_pkg::KEY_W'(b);
            o_level[b] = i_mods_new[b];
        end
        for (int i = 0; i < SLOTS; i++) begin
            o_cand[MB + i]          = !w_rollover && w_live_new[i] && !w_in_old[i];
            o_usage[MB + i]         = i_fresh[i];
            o_level[MB + i]         = 1'b1;
            o_cand[MB + SLOTS + i]  = !w_rollover && w_live_old[i] && !w_in_new[i];
            o_usage[MB + SLOTS + i] = i_old[i];
            o_level[MB + SLOTS + i] = 1'b0;
        end
    end

endmodule

[src/hid_boot_keyboard_report_differ.sv]
// ----------------------------------------------------------------------------
// hid_boot_keyboard_report_differ
// Compares each boot keyboard report with the previous one and emits key
// press and release events, one item per event.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready): one report per item, the modifier
// byte, six key slots and a completeness flag. An incomplete report is
// swallowed with no events and leaves the stored report alone.
// Output channel (o_out_valid / i_out_ready): one event per item, carrying
// the usage, press or release level, the current modifier byte and a flag on
// the last event of the report.
// The lanes compare the whole report in the accept cycle; its events go into
// the pending list and from there, lowest first, into the output register.
// Events leave one per cycle while the receiver is ready, modifier changes
// first (bit 0 first), then presses, then releases. The input stays closed
// until the last event of a report has moved into the output register, and
// opens even while that event still waits there; a report that changes
// nothing leaves no events and the input stays open.
// Reset clears the stored report to all zero and drops pending events.
// When the receiver stalls, the output register holds its event and the
// pending list waits; no event is lost or repeated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hid_boot_keyboard_report_differ #(
    parameter int KEY_SLOTS = hbkrd_pkg::KEY_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_report_complete,
    input  hbkrd_pkg::t_key     i_modifier_bits,
    input  hbkrd_pkg::t_key     i_slot_a,
    input  hbkrd_pkg::t_key     i_slot_b,
    input  hbkrd_pkg::t_key     i_slot_c,
    input  hbkrd_pkg::t_key     i_slot_d,
    input  hbkrd_pkg::t_key     i_slot_e,
    input  hbkrd_pkg::t_key     i_slot_f,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hbkrd_pkg::t_key     o_key_usage,
    output logic                o_pressed,
    output hbkrd_pkg::t_key     o_modifier_state,
    output logic                o_last_event
);

    // Only the slots that take part are stored; the rest would stay zero.
    localparam int USED  = hbkrd_pkg::used_slots(KEY_SLOTS);
    localparam int NCAND = hbkrd_pkg::MOD_BITS + 2 * USED;
    localparam int IDX_W = $clog2(NCAND);

    hbkrd_pkg::t_key [hbkrd_pkg::INPUT_SLOTS-1:0] w_slots;
    hbkrd_pkg::t_key [USED-1:0]                   w_fresh;

    // Stored report.
    hbkrd_pkg::t_key                r_old_mods;
    hbkrd_pkg::t_key [USED-1:0]     r_old_slots;

    // Pending events of the report being emitted.
    logic [NCAND-1:0]               r_pend;
    hbkrd_pkg::t_key [NCAND-1:0]    r_usage;
    logic [NCAND-1:0]               r_level;
    hbkrd_pkg::t_key                r_cur_mods;

    // Output register.
    logic                           r_out_valid;
    hbkrd_pkg::t_key                r_out_usage;
    logic                           r_out_pressed;
    hbkrd_pkg::t_key                r_out_mods;
    logic                           r_out_last;

    logic [NCAND-1:0]               w_cand;
    hbkrd_pkg::t_key [NCAND-1:0]    w_usage;
    logic [NCAND-1:0]               w_level;
    logic [NCAND-1:0]               w_first;
    logic [NCAND-1:0]               n_pend;
    logic [IDX_W-1:0]               w_idx;
    logic                           w_in_fire;
    logic                           w_load;

    assign w_slots = {i_slot_f, i_slot_e, i_slot_d, i_slot_c, i_slot_b, i_slot_a};
    assign w_fresh = w_slots[USED-1:0];

    hbkrd_merge #(.SLOTS(USED), .NCAND(NCAND)) u_merge (
        .i_mods_new (i_modifier_bits),
        .i_mods_old (r_old_mods),
        .i_fresh    (w_fresh),
        .i_old      (r_old_slots),
        .o_cand     (w_cand),
        .o_usage    (w_usage),
        .o_level    (w_level)
    );

    // A new report is taken only once every event of the last one has moved
    // into the output register.
    assign o_in_ready = (r_pend == '0);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_load     = (r_pend != '0) && (!r_out_valid || i_out_ready);

    // Lowest pending candidate is the next event in order.
    assign w_first = r_pend & (~r_pend + NCAND'(1));
    assign n_pend  = r_pend & ~w_first;

    always_comb begin
        w_idx = '0;
        for (int i = 0; i < NCAND; i++) begin
            if (w_first[i]) begin
                w_idx = w_idx | IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old_mods  <= '0;
            r_old_slots <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_fire && i_report_complete) begin
                r_old_mods  <= i_modifier_bits;
                r_old_slots <= w_fresh;
                r_pend      <= w_cand;
            end else if (w_load) begin
                r_pend      <= n_pend;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire && i_report_complete) begin
            r_usage    <= w_usage;
            r_level    <= w_level;
            r_cur_mods <= i_modifier_bits;
        end
        if (w_load) begin
            r_out_usage   <= r_usage[w_idx];
            r_out_pressed <= r_level[w_idx];
            r_out_mods    <= r_cur_mods;
            r_out_last    <= (n_pend == '0);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_key_usage      = r_out_usage;
    assign o_pressed        = r_out_pressed;
    assign o_modifier_state = r_out_mods;
    assign o_last_event     = r_out_last;

    // An event that is not the last one always leaves others of its report
    // pending behind it.
    `ASSERT_SAME(a_more_pending, i_clk, i_rst_n, o_out_valid && !o_last_event, r_pend != '0)

    // A dropped report leaves the stored modifier byte alone.
    `ASSERT_NEXT(a_drop_keeps, i_clk, i_rst_n, w_in_fire && !i_report_complete, $stable(r_old_mods))

    // Key events only come from live list entries, never from an empty slot.
    `ASSERT_SAME(a_no_empty_key, i_clk, i_rst_n, o_out_valid, o_key_usage != hbkrd_pkg::EMPTY_CODE)

endmodule
